@@ hdl/lppd_pkg.sv @@
package lppd_pkg;

  // one raw byte of the batch stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_batch;
  } lppd_in_t;

  // one result request
  typedef struct packed {
    logic [15:0] packet_opcode;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        packet_valid;
    logic        packet_end;
    logic        batch_end;
    logic        batch_error;
  } lppd_out_t;

  // request handed from the parser to the result queue
  typedef struct packed {
    logic      push;
    lppd_out_t data;
  } lppd_res_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [7:0]  MIN_SIZE    = 8'd2;

endpackage

@@ hdl/length_prefixed_packet_deframer.sv @@
// length-prefixed packet deframer
// input channel: push / full with in_data {data_byte, last_in_batch}; a byte
//   is taken at a clock edge with push high and full low
// result channel: empty / pop with out_data; the oldest result request sits
//   on out_data while empty is low and leaves on an edge with pop high
// each batch starts with HEADER_BYTES skipped header bytes, then sub-packets
//   of a size byte, a little-endian opcode and size-2 payload bytes
// every payload byte gives one result tagged with its opcode; a packet with
//   no payload gives one result once its opcode is in; the final batch byte
//   always gives a result with batch_end, and batch_error set if the batch
//   was malformed (the consumer then drops the whole batch)
// each result is written into the queue at the clock edge that takes its byte
// throughput: one byte per cycle while full is low; the parser state update is the only loop
// the parser writes into a small result queue, so bytes keep flowing while
//   the receiver stalls until the queue fills, and then full rises
// reset (rst_n low, synchronous) empties the queue and returns the parser
//   to the start of a batch
module length_prefixed_packet_deframer
  import lppd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  lppd_in_t  in_data,
  output logic      empty,
  input  logic      pop,
  output lppd_out_t out_data
);

  logic      acc;
  lppd_res_t res;

  // a byte is taken whenever push is high and the queue has room
  assign acc = push & ~full;

  // front: header skip, size/opcode decode, error latch
  lppd_parse #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .in_data(in_data),
    .res    (res)
  );

  // back: result queue toward the consumer
  lppd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .res     (res),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

`ifndef SYNTHESIS
  // a batch-final byte always leaves a request in the queue
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && in_data.last_in_batch |=> !empty)
    else $error("batch end byte produced no result");

  // error only rides on a batch end request
  a_err_with_end: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.batch_error |-> out_data.batch_end)
    else $error("batch_error without batch_end");

  // payload data only inside a packet
  a_payload_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.payload_valid |-> out_data.packet_valid)
    else $error("payload_valid without packet_valid");

  // queue cannot be full and empty at once
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && empty))
    else $error("queue full and empty together");
`endif

endmodule

@@ hdl/lppd_parse.sv @@
module lppd_parse
  import lppd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  lppd_in_t  in_data,
  output lppd_res_t res
);

  localparam int unsigned HC_W = (HEADER_BYTES > 0) ? $clog2(HEADER_BYTES + 1) : 1;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SIZE    = 3'd1,
    PH_OPLO    = 3'd2,
    PH_OPHI    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  localparam phase_t START_PHASE = (HEADER_BYTES > 0) ? PH_HEADER : PH_SIZE;

  phase_t            phase_r, phase_nxt;
  logic [HC_W-1:0]   hc_r, hc_nxt;
  logic [HC_W:0]     hc_inc;
  logic [7:0]        rem_r, rem_nxt, rem_dec;
  logic [15:0]       opc_r, opc_nxt;
  logic              err_r, err_nxt;
  logic              emit;
  lppd_out_t         r;

  assign hc_inc  = {1'b0, hc_r} + (HC_W + 1)'(1);
  assign rem_dec = rem_r - 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    hc_nxt    = hc_r;
    rem_nxt   = rem_r;
    opc_nxt   = opc_r;
    err_nxt   = err_r;
    emit      = 1'b0;
    r         = '0;
    unique case (phase_r)
      PH_HEADER: begin
        hc_nxt = hc_inc[HC_W-1:0];
        if (hc_inc >= (HC_W + 1)'(HEADER_BYTES)) begin
          phase_nxt = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (in_data.data_byte < MIN_SIZE) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_DISCARD;
        end else begin
          rem_nxt   = in_data.data_byte;
          phase_nxt = PH_OPLO;
        end
      end
      PH_OPLO: begin
        opc_nxt   = {8'd0, in_data.data_byte};
        rem_nxt   = rem_dec;
        phase_nxt = PH_OPHI;
      end
      PH_OPHI: begin
        opc_nxt = {in_data.data_byte, opc_r[7:0]};
        rem_nxt = rem_dec;
        if (rem_dec == 8'd0) begin
          emit            = 1'b1;
          r.packet_valid  = 1'b1;
          r.packet_end    = 1'b1;
          r.packet_opcode = {in_data.data_byte, opc_r[7:0]};
          phase_nxt       = PH_SIZE;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit            = 1'b1;
        r.packet_valid  = 1'b1;
        r.payload_valid = 1'b1;
        r.payload_byte  = in_data.data_byte;
        r.packet_opcode = opc_r;
        rem_nxt         = rem_dec;
        if (rem_dec == 8'd0) begin
          r.packet_end = 1'b1;
          phase_nxt    = PH_SIZE;
        end
      end
      default: begin
        // discard phase and unused codes: ignore the byte
      end
    endcase

    if (in_data.last_in_batch) begin
      emit          = 1'b1;
      r.batch_end   = 1'b1;
      r.batch_error = err_nxt | (phase_nxt != PH_SIZE);
      phase_nxt     = START_PHASE;
      hc_nxt        = '0;
      rem_nxt       = '0;
      opc_nxt       = '0;
      err_nxt       = 1'b0;
    end
  end

  assign res.push = acc & emit;
  assign res.data = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= START_PHASE;
      hc_r    <= '0;
      rem_r   <= '0;
      opc_r   <= '0;
      err_r   <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      rem_r   <= rem_nxt;
      opc_r   <= opc_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

@@ hdl/lppd_fifo.sv @@
module lppd_fifo
  import lppd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lppd_res_t res,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output lppd_out_t out_data
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  lppd_out_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_wr    = res.push & ~full;
  assign do_rd    = pop & ~empty;
  assign out_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= res.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
